FILE: rtl/assert_macros.svh
// Shared assertion macros; every use samples clk and is disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check cons in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/hcu_pkg.sv
package hcu_pkg;

  localparam int CELL_W = 8;   // cell state width
  localparam int SUM_W  = 12;  // nine-cell sum, up to 9*255
  localparam int CNT_W  = 4;   // neighbour counts, up to 8
  localparam int IDX_W  = 7;   // reported cell index width
  localparam int ITER_W = 4;   // divider step counter

  localparam logic [ITER_W-1:0] ITER_SUM = 4'd12;  // steps for the sum division
  localparam logic [ITER_W-1:0] ITER_CNT = 4'd4;   // steps for a count division
  localparam logic [3:0]        TAP_LAST = 4'd8;   // nine taps, centre first

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_NUM_STATES = 2'd0,
    CFG_DIV_INF    = 2'd1,
    CFG_DIV_ILL    = 2'd2,
    CFG_GAIN       = 2'd3
  } cfg_idx_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ACCUM = 5'b00010,
    S_PREP  = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

FILE: rtl/hodgepodge_cell_update_top.sv
// Channel   Signals                                          Direction
// in        in_valid/in_ready, in_cell_state, in_frame_start  input
// out       out_valid/out_ready, out_new_state,               output
//           out_cell_index, out_last_of_frame
// cfg       cfg_wr_en, cfg_index, cfg_data                    input, write only
//
// An item that yields no result is only accepted. An interior cell is accepted,
// its nine taps are accumulated in turn through one adder, a setup state follows,
// then the shared radix-2 divider: one sum division for an infected centre, two
// count divisions for a healthy one, none for an ill one; a last state loads the
// output register.
// Reset (rst_n, synchronous) clears the window, position, config, state and output valid.
// A result waiting on out_ready holds the sequencer in its final state once the
// next result is done; no input is taken while it waits there.
`include "assert_macros.svh"

module hodgepodge_cell_update_top import hcu_pkg::*; #(
  parameter int ROW_WIDTH   = 16,
  parameter int FRAME_CELLS = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CELL_W-1:0] in_cell_state,
  input  logic              in_frame_start,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CELL_W-1:0] out_new_state,
  output logic [IDX_W-1:0]  out_cell_index,
  output logic              out_last_of_frame,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [CELL_W-1:0] cfg_data
);

  localparam int WIN_DEPTH  = 2 * ROW_WIDTH + 3;
  localparam int POS_W      = $clog2(FRAME_CELLS);
  localparam int EMIT_FIRST = 2 * ROW_WIDTH + 2;
  // window taps: entry k holds the cell that arrived k items ago
  localparam int K_C  = ROW_WIDTH + 1;
  localparam int K_W  = ROW_WIDTH + 2;
  localparam int K_E  = ROW_WIDTH;
  localparam int K_N  = 2 * ROW_WIDTH + 1;
  localparam int K_S  = 1;
  localparam int K_NW = 2 * ROW_WIDTH + 2;
  localparam int K_NE = 2 * ROW_WIDTH;
  localparam int K_SW = 2;
  localparam int K_SE = 0;

  // configuration
  logic [CELL_W-1:0] num_states_r, div_inf_r, div_ill_r, gain_r;
  logic [CELL_W-1:0] ill;
  logic [CELL_W-1:0] k1, k2;

  // stream position and window
  logic [CELL_W-1:0] win_r [WIN_DEPTH];
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              emit;

  // sequencer and datapath
  state_t              state_r, state_nxt;
  logic [3:0]          tap_r, tap_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]    n_ill_r, n_ill_nxt, n_inf_r, n_inf_nxt;
  logic [CELL_W-1:0]   tap_v, centre;
  logic [CELL_W-1:0]   res_r, res_nxt, clamped;
  logic                infected_r, infected_nxt, phase_r, phase_nxt;
  logic [IDX_W-1:0]    cidx_r, cidx_nxt;
  logic                last_r, last_nxt;

  // shared divider
  logic [SUM_W-1:0]    dvd_r, dvd_nxt, dvd_step;
  logic [CELL_W-1:0]   rem_r, rem_nxt, rem_step, dsr_r, dsr_nxt;
  logic [ITER_W-1:0]   iter_r, iter_nxt;
  logic [CELL_W:0]     rem_sh;
  logic                ge;

  // output register
  logic                out_valid_r, out_valid_nxt, out_free;
  logic [CELL_W-1:0]   out_state_r;
  logic [IDX_W-1:0]    out_idx_r;
  logic                out_last_r;

  logic                in_acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  assign ill     = num_states_r - 8'd1;
  assign k1      = (div_inf_r == '0) ? 8'd1 : div_inf_r;
  assign k2      = (div_ill_r == '0) ? 8'd1 : div_ill_r;
  assign centre  = win_r[K_C];
  assign clamped = (res_r > ill) ? ill : res_r;

  // write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_states_r <= 8'd100;
      div_inf_r    <= 8'd1;
      div_ill_r    <= 8'd1;
      gain_r       <= 8'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_NUM_STATES: num_states_r <= cfg_data;
        CFG_DIV_INF:    div_inf_r    <= cfg_data;
        CFG_DIV_ILL:    div_ill_r    <= cfg_data;
        CFG_GAIN:       gain_r       <= cfg_data;
        default:        ;
      endcase
    end
  end

  // advance position; restart on frame start or after the last cell
  always_comb begin
    if (in_frame_start) begin
      pos_nxt = '0;
    end else if ((32'(pos_r) + 32'd1) >= FRAME_CELLS) begin
      pos_nxt = '0;
    end else begin
      pos_nxt = POS_W'(32'(pos_r) + 32'd1);
    end
    emit     = (32'(pos_nxt) >= EMIT_FIRST);
    cidx_nxt = IDX_W'(32'(pos_nxt) - 32'(K_C));
    last_nxt = (32'(pos_nxt) == FRAME_CELLS - 1);
  end

  // shift the window on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      for (int i = 0; i < WIN_DEPTH; i++) win_r[i] <= '0;
    end else if (in_acc) begin
      pos_r    <= pos_nxt;
      win_r[0] <= in_cell_state;
      for (int i = 1; i < WIN_DEPTH; i++) win_r[i] <= win_r[i-1];
    end
  end

  // select one tap per accumulation cycle
  always_comb begin
    unique case (tap_r)
      4'd0:    tap_v = win_r[K_C];
      4'd1:    tap_v = win_r[K_W];
      4'd2:    tap_v = win_r[K_E];
      4'd3:    tap_v = win_r[K_N];
      4'd4:    tap_v = win_r[K_S];
      4'd5:    tap_v = win_r[K_NW];
      4'd6:    tap_v = win_r[K_NE];
      4'd7:    tap_v = win_r[K_SW];
      4'd8:    tap_v = win_r[K_SE];
      default: tap_v = '0;
    endcase
  end

  // one restoring divider step
  always_comb begin
    rem_sh   = {rem_r, dvd_r[SUM_W-1]};
    ge       = (rem_sh >= {1'b0, dsr_r});
    rem_step = ge ? CELL_W'(rem_sh - {1'b0, dsr_r}) : CELL_W'(rem_sh);
    dvd_step = {dvd_r[SUM_W-2:0], ge};
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    tap_nxt       = tap_r;
    sum_nxt       = sum_r;
    n_ill_nxt     = n_ill_r;
    n_inf_nxt     = n_inf_r;
    res_nxt       = res_r;
    infected_nxt  = infected_r;
    phase_nxt     = phase_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    iter_nxt      = iter_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && emit) begin
          state_nxt = S_ACCUM;
          tap_nxt   = '0;
          sum_nxt   = '0;
          n_ill_nxt = '0;
          n_inf_nxt = '0;
        end
      end
      S_ACCUM: begin
        // add one tap; the centre is tap zero and is summed but not classified
        sum_nxt = sum_r + SUM_W'(tap_v);
        if (tap_r != 4'd0) begin
          if (tap_v == ill) begin
            n_ill_nxt = n_ill_r + 4'd1;
          end else if (tap_v != '0) begin
            n_inf_nxt = n_inf_r + 4'd1;
          end
        end
        tap_nxt = tap_r + 4'd1;
        if (tap_r == TAP_LAST) state_nxt = S_PREP;
      end
      S_PREP: begin
        rem_nxt   = '0;
        phase_nxt = 1'b0;
        if (centre == '0) begin
          infected_nxt = 1'b0;
          dvd_nxt      = {n_inf_r, 8'd0};
          dsr_nxt      = k1;
          iter_nxt     = ITER_CNT;
          state_nxt    = S_DIV;
        end else if (centre < ill) begin
          infected_nxt = 1'b1;
          dvd_nxt      = sum_r;
          dsr_nxt      = CELL_W'(n_inf_r) + 8'd1;
          iter_nxt     = ITER_SUM;
          state_nxt    = S_DIV;
        end else begin
          res_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        rem_nxt  = rem_step;
        dvd_nxt  = dvd_step;
        iter_nxt = iter_r - 4'd1;
        if (iter_r == 4'd1) begin
          if (infected_r) begin
            res_nxt   = dvd_step[CELL_W-1:0] + gain_r;
            state_nxt = S_DONE;
          end else if (!phase_r) begin
            // first quotient held, start the ill-count division
            res_nxt   = CELL_W'(dvd_step[CNT_W-1:0]);
            phase_nxt = 1'b1;
            rem_nxt   = '0;
            dvd_nxt   = {n_ill_r, 8'd0};
            dsr_nxt   = k2;
            iter_nxt  = ITER_CNT;
          end else begin
            res_nxt   = res_r + CELL_W'(dvd_step[CNT_W-1:0]);
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    tap_r      <= tap_nxt;
    sum_r      <= sum_nxt;
    n_ill_r    <= n_ill_nxt;
    n_inf_r    <= n_inf_nxt;
    res_r      <= res_nxt;
    infected_r <= infected_nxt;
    phase_r    <= phase_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    dsr_r      <= dsr_nxt;
    iter_r     <= iter_nxt;
    if (in_acc) begin
      cidx_r <= cidx_nxt;
      last_r <= last_nxt;
    end
    if (state_r == S_DONE && out_free) begin
      out_state_r <= clamped;
      out_idx_r   <= cidx_r;
      out_last_r  <= last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_new_state     = out_state_r;
  assign out_cell_index    = out_idx_r;
  assign out_last_of_frame = out_last_r;

  `ASSERT_NEXT(a_emit_starts, in_acc && emit, state_r == S_ACCUM)
  `ASSERT_IMPL(a_div_rem, state_r == S_DIV, rem_r < dsr_r)
  `ASSERT_IMPL(a_div_iter, state_r == S_DIV, iter_r != '0)
  `ASSERT_IMPL(a_out_clamped, out_valid_r, out_state_r <= ill)
  `ASSERT_IMPL(a_healthy_bound, state_r == S_DONE && centre == '0, res_r <= 8'd16)

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import hcu_pkg::*;

  localparam int ROW_W      = 16;
  localparam int FRAME_N    = 128;
  localparam int WIN_DEPTH  = 2 * ROW_W + 3;
  localparam int FIRST_EMIT = 2 * ROW_W + 2;
  localparam int SETTLE     = 40;     // longer than the longest cell latency
  localparam int WDOG_LIMIT = 4000;
  localparam int PHASE_N    = 141;    // cells per register setting
  localparam int MAX_REPORT = 40;

  typedef struct packed {
    logic [CELL_W-1:0] cell_state;
    logic              frame_start;
  } cell_item_t;

  typedef struct packed {
    logic [CELL_W-1:0] new_state;
    logic [IDX_W-1:0]  cell_index;
    logic              last_of_frame;
  } cell_update_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CELL_W-1:0] in_cell_state = '0;
  logic              in_frame_start = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CELL_W-1:0] out_new_state;
  logic [IDX_W-1:0]  out_cell_index;
  logic              out_last_of_frame;
  logic              cfg_wr_en = 1'b0;
  logic [1:0]        cfg_index = CFG_NUM_STATES;
  logic [CELL_W-1:0] cfg_data = '0;

  // Shadow of the block: registers, neighbour window and frame position
  logic [CELL_W-1:0] q_shadow    = 8'd100;
  logic [CELL_W-1:0] k1_shadow   = 8'd1;
  logic [CELL_W-1:0] k2_shadow   = 8'd1;
  logic [CELL_W-1:0] gain_shadow = 8'd0;
  logic [CELL_W-1:0] cell_window [WIN_DEPTH];
  int unsigned       frame_pos = 0;

  cell_item_t   pending_cells [$];
  cell_update_t updates_due [$];
  cell_item_t   drv_item;

  int cells_queued = 0;
  int cells_taken = 0;
  int updates_seen = 0;
  int fault_cnt = 0;
  int settings_cnt = 1;
  int gen_idx = 0;
  int send_gap = 0;
  int send_calm = 0;
  int recv_hold = 0;
  int recv_calm = 0;
  int quiet_cycles = 0;

  hodgepodge_cell_update_top #(
    .ROW_WIDTH   (ROW_W),
    .FRAME_CELLS (FRAME_N)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cell_state     (in_cell_state),
    .in_frame_start    (in_frame_start),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_new_state     (out_new_state),
    .out_cell_index    (out_cell_index),
    .out_last_of_frame (out_last_of_frame),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    foreach (cell_window[k]) cell_window[k] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Mostly short gaps, a few long ones, and now and then a stretch with none
  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Neighbour at offset d from the centre; the centre sits at entry ROW_W+1
  function automatic int unsigned window_cell(int d);
    return 32'(cell_window[ROW_W + 1 - d]);
  endfunction

  function automatic logic [CELL_W-1:0] hodgepodge_rule();
    int offs [8];
    int unsigned ill, k1, k2, s, v, sum, n_ill, n_inf, r;
    offs = '{-1, 1, -ROW_W, ROW_W, -ROW_W - 1, -ROW_W + 1, ROW_W - 1, ROW_W + 1};
    ill = 8'(q_shadow - 8'd1);
    k1 = (k1_shadow == 0) ? 1 : k1_shadow;
    k2 = (k2_shadow == 0) ? 1 : k2_shadow;
    s = window_cell(0);
    sum = s;
    n_ill = 0;
    n_inf = 0;
    foreach (offs[i]) begin
      v = window_cell(offs[i]);
      sum += v;
      if (v == ill) n_ill++;
      else if (v != 0) n_inf++;
    end
    if (s == 0) r = n_inf / k1 + n_ill / k2;
    else if (s < ill) r = (sum / (n_inf + 1) + gain_shadow) & 8'hFF;
    else r = 0;
    if (r > ill) r = ill;
    return r[CELL_W-1:0];
  endfunction

  // Advance position and window for one taken cell; queue its update if any
  task automatic track_cell(logic [CELL_W-1:0] cell_in, logic fs);
    cell_update_t upd;
    if (fs) frame_pos = 0;
    else if (frame_pos + 1 >= FRAME_N) frame_pos = 0;
    else frame_pos++;
    for (int k = WIN_DEPTH - 1; k > 0; k--) cell_window[k] = cell_window[k - 1];
    cell_window[0] = cell_in;
    if (frame_pos >= FIRST_EMIT && frame_pos < FRAME_N) begin
      upd.new_state     = hodgepodge_rule();
      upd.cell_index    = IDX_W'(frame_pos - (ROW_W + 1));
      upd.last_of_frame = (frame_pos == FRAME_N - 1);
      updates_due.push_back(upd);
    end
  endtask

  // Driver: hold the item until taken, then idle a random gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) send_gap = draw_gap(send_calm);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_cells.size() > 0) begin
        drv_item = pending_cells.pop_front();
        in_valid       <= 1'b1;
        in_cell_state  <= drv_item.cell_state;
        in_frame_start <= drv_item.frame_start;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall at random, also while nothing is offered
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && out_ready) recv_hold = draw_gap(recv_calm);
      else if (!out_valid && recv_hold == 0 && $urandom_range(0, 15) == 0)
        recv_hold = $urandom_range(1, 6);
      if (recv_hold > 0) begin
        recv_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: check each update against the oldest one due, then predict
  always @(posedge clk) begin
    cell_update_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        updates_seen++;
        if (updates_due.size() == 0) begin
          fault_cnt++;
          $display("%0t unexpected update: new_state %0d cell_index %0d last %0b",
                   $time, out_new_state, out_cell_index, out_last_of_frame);
        end else begin
          want = updates_due.pop_front();
          if (out_new_state !== want.new_state) begin
            fault_cnt++;
            if (fault_cnt <= MAX_REPORT)
              $display("%0t mismatch new_state: expected %0d actual %0d (cell %0d)",
                       $time, want.new_state, out_new_state, want.cell_index);
          end
          if (out_cell_index !== want.cell_index) begin
            fault_cnt++;
            if (fault_cnt <= MAX_REPORT)
              $display("%0t mismatch cell_index: expected %0d actual %0d",
                       $time, want.cell_index, out_cell_index);
          end
          if (out_last_of_frame !== want.last_of_frame) begin
            fault_cnt++;
            if (fault_cnt <= MAX_REPORT)
              $display("%0t mismatch last_of_frame: expected %0b actual %0b (cell %0d)",
                       $time, want.last_of_frame, out_last_of_frame, want.cell_index);
          end
        end
      end
      if (in_valid && in_ready) begin
        track_cell(in_cell_state, in_frame_start);
        cells_taken++;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
        quiet_cycles <= 0;
      else if (quiet_cycles + 1 >= WDOG_LIMIT) begin
        $display("%0t watchdog: no item moved for %0d cycles, %0d updates still due",
                 $time, WDOG_LIMIT, updates_due.size());
        $display("tb: FAIL");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Pick a cell value: mostly healthy, ill or infected under the current q
  function automatic logic [CELL_W-1:0] pick_cell();
    int unsigned ill, r;
    ill = 8'(q_shadow - 8'd1);
    r = $urandom_range(0, 99);
    if (r < 30) return '0;
    if (r < 55) return ill[CELL_W-1:0];
    if (r < 88 && ill >= 2) return CELL_W'($urandom_range(1, ill - 1));
    return CELL_W'($urandom_range(0, 255));
  endfunction

  // Queue n cells with random content, some implicit wraps and restarts
  task automatic queue_cells(int n);
    cell_item_t it;
    for (int i = 0; i < n; i++) begin
      if (i == 0) it.frame_start = 1'b1;
      else if (gen_idx == 0) it.frame_start = ($urandom_range(0, 3) != 0);
      else it.frame_start = ($urandom_range(0, 199) == 0);
      gen_idx = it.frame_start ? 1 : (gen_idx + 1) % FRAME_N;
      it.cell_state = pick_cell();
      pending_cells.push_back(it);
      cells_queued++;
    end
  endtask

  // Wait until every cell is taken and every update is in, then settle
  task automatic wait_idle();
    do @(posedge clk);
    while (cells_taken != cells_queued || updates_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CELL_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_NUM_STATES: q_shadow    = val;
      CFG_DIV_INF:    k1_shadow   = val;
      CFG_DIV_ILL:    k2_shadow   = val;
      CFG_GAIN:       gain_shadow = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic apply_setting(logic [7:0] q, logic [7:0] k1, logic [7:0] k2,
                               logic [7:0] g);
    write_reg(CFG_NUM_STATES, q);
    write_reg(CFG_DIV_INF, k1);
    write_reg(CFG_DIV_ILL, k2);
    write_reg(CFG_GAIN, g);
    settings_cnt++;
  endtask

  initial begin
    cell_item_t it;
    do @(posedge clk);
    while (!rst_n);

    // Extreme values, then an early restart in the middle of the frame
    for (int i = 0; i < 20; i++) begin
      it.frame_start = (i == 0 || i == 10);
      case (i % 4)
        0: it.cell_state = 8'hFF;
        1: it.cell_state = 8'h00;
        2: it.cell_state = 8'h80;
        default: it.cell_state = 8'h7F;
      endcase
      pending_cells.push_back(it);
      cells_queued++;
    end

    // Reset register values first, then the extremes, then random settings
    queue_cells(PHASE_N);
    for (int p = 1; p < 8; p++) begin
      wait_idle();
      case (p)
        1: apply_setting(8'd255, 8'd0, 8'd0, 8'd255);
        2: apply_setting(8'd0, 8'd255, 8'd255, 8'd0);
        3: apply_setting(8'd1, 8'd1, 8'd2, 8'd7);
        4: apply_setting(8'd2, 8'd2, 8'd0, 8'd1);
        5: apply_setting(8'($urandom_range(3, 12)), 8'($urandom_range(0, 4)),
                         8'($urandom_range(0, 4)), 8'($urandom_range(0, 20)));
        6: apply_setting(8'($urandom_range(13, 255)), 8'($urandom_range(0, 9)),
                         8'($urandom_range(0, 9)), 8'($urandom_range(0, 255)));
        default: apply_setting(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      queue_cells(PHASE_N);
    end
    wait_idle();

    $display("tb: %0d cells driven, %0d cell updates checked under %0d register settings",
             cells_taken, updates_seen, settings_cnt);
    $display("tb: settings include q of 0, 1, 2 and 255, zero divisors and full gain");
    if (fault_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: %0d field mismatches or unexpected updates", fault_cnt);
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/hcu_pkg.sv
rtl/hodgepodge_cell_update_top.sv
tb/sv/tb.sv
